/* rtl/ffha_pkg.sv */
package ffha_pkg;

   localparam int unsigned DEF_HEAP_BYTES = 4096;
   localparam int unsigned REQ_W          = 13;
   localparam int unsigned OFF_W          = 12;
   localparam int unsigned HDR_BYTES      = 8;
   localparam int unsigned SPLIT_MIN      = 16;
   localparam int unsigned END_MARK       = 1;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

endpackage

/* rtl/ffha_req_if.sv */
interface ffha_req_if import ffha_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             mode;
   logic [REQ_W-1:0] request_bytes;
   logic [OFF_W-1:0] free_offset;

   modport source (output valid, mode, request_bytes, free_offset, input ready);
   modport sink   (input valid, mode, request_bytes, free_offset, output ready);
endinterface

/* rtl/ffha_rsp_if.sv */
interface ffha_rsp_if import ffha_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             status;
   logic [OFF_W-1:0] payload_offset;

   modport source (output valid, status, payload_offset, input ready);
   modport sink   (input valid, status, payload_offset, output ready);
endinterface

/* rtl/first_fit_heap_allocator.sv */
// channel   dir  handshake           payload
// req_if    in   valid / ready       mode, request_bytes, free_offset
// rsp_if    out  valid / ready       status, payload_offset
//
// an allocate walks the headers (ST_RD, ST_EX), then ST_ASPLIT on a split and ST_AHEAD;
// a free walks the headers up to the target, then merges in ST_NRD, ST_NEX and ST_PMRG
// the walk is bound by the single header memory read port: one read per visited header
// after reset ST_INIT0 writes the initial free block and ST_INIT1 the end mark, ready stays low
// a finished result waits in the output register; the next request is taken meanwhile,
// and a second result holds in the done state until the first one is taken
module first_fit_heap_allocator import ffha_pkg::*; #(
   parameter int unsigned HEAP_BYTES = DEF_HEAP_BYTES
) (
   input  logic              clock,
   input  logic              reset,
   ffha_req_if.sink          req_if,
   ffha_rsp_if.source        rsp_if
);

   localparam int unsigned AW = $clog2(HEAP_BYTES);
   localparam int unsigned SW = AW + 1;
   localparam int unsigned CW = SW + 1;
   localparam int unsigned XW = (CW > OFF_W) ? CW : OFF_W;
   localparam int unsigned RW = (SW > REQ_W) ? SW : REQ_W;
   localparam int unsigned EW = 2 * SW;

   localparam logic [CW-1:0] HEAP_C = CW'(HEAP_BYTES);
   localparam logic [CW-1:0] HDR_C  = CW'(HDR_BYTES);
   localparam logic [SW-1:0] HDR_S  = SW'(HDR_BYTES);
   localparam logic [SW-1:0] SPL_S  = SW'(SPLIT_MIN);
   localparam logic [SW-1:0] END_S  = SW'(END_MARK);

   localparam logic [3:0] ST_INIT0  = 4'd0;
   localparam logic [3:0] ST_INIT1  = 4'd1;
   localparam logic [3:0] ST_IDLE   = 4'd2;
   localparam logic [3:0] ST_RD     = 4'd3;
   localparam logic [3:0] ST_EX     = 4'd4;
   localparam logic [3:0] ST_ASPLIT = 4'd5;
   localparam logic [3:0] ST_AHEAD  = 4'd6;
   localparam logic [3:0] ST_NRD    = 4'd7;
   localparam logic [3:0] ST_NEX    = 4'd8;
   localparam logic [3:0] ST_PMRG   = 4'd9;
   localparam logic [3:0] ST_DONE   = 4'd10;

   // header store: {size word, payload length}
   logic [EW-1:0] mem [HEAP_BYTES];
   logic [EW-1:0] rd_data_ff;

   logic          mem_we;
   logic [AW-1:0] mem_wa;
   logic [EW-1:0] mem_wd;
   logic [AW-1:0] mem_ra;

   logic [3:0]       state_ff, state_in;
   logic             mode_ff, mode_in;
   logic [REQ_W-1:0] req_ff, req_in;
   logic [OFF_W-1:0] target_ff, target_in;
   logic [CW-1:0]    cur_ff, cur_in;
   logic [AW-1:0]    prev_ff, prev_in;
   logic [SW-1:0]    prev_size_ff, prev_size_in;
   logic             have_prev_ff, have_prev_in;
   logic [SW-1:0]    hsize_ff, hsize_in;
   logic [CW-1:0]    nh_ff, nh_in;
   logic [SW-1:0]    rest_ff, rest_in;
   logic             res_status_ff, res_status_in;
   logic [OFF_W-1:0] res_off_ff, res_off_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_status_ff, rsp_status_in;
   logic [OFF_W-1:0] rsp_off_ff, rsp_off_in;

   logic [SW-1:0] rd_size;
   logic [SW-1:0] rd_pay;
   logic [SW-1:0] rd_size_m;
   logic          rd_live;
   logic [SW-1:0] req_s;
   logic [SW-1:0] spare;
   logic [SW-1:0] keep;
   logic [CW-1:0] nx;
   logic [SW-1:0] merged;
   logic [SW-1:0] pmerged;
   logic          prev_merge;

   assign rd_size    = rd_data_ff[EW-1:SW];
   assign rd_pay     = rd_data_ff[SW-1:0];
   assign rd_size_m  = {rd_size[SW-1:1], 1'b0};
   assign rd_live    = (rd_size != END_S) && (rd_size[SW-1:1] != '0);
   assign req_s      = SW'(req_ff);
   assign spare      = rd_pay - req_s;
   assign keep       = {{(SW-4){1'b0}}, spare[3:0]};
   assign nx         = cur_ff + CW'(hsize_ff);
   assign merged     = hsize_ff + rd_size;
   assign pmerged    = prev_size_ff + hsize_ff;
   assign prev_merge = have_prev_ff && !prev_size_ff[0];

   assign req_if.ready          = (state_ff == ST_IDLE);
   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.status         = rsp_status_ff;
   assign rsp_if.payload_offset = rsp_off_ff;

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      req_in        = req_ff;
      target_in     = target_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      prev_size_in  = prev_size_ff;
      have_prev_in  = have_prev_ff;
      hsize_in      = hsize_ff;
      nh_in         = nh_ff;
      rest_in       = rest_ff;
      res_status_in = res_status_ff;
      res_off_in    = res_off_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in = rsp_status_ff;
      rsp_off_in    = rsp_off_ff;
      mem_we        = 1'b0;
      mem_wa        = cur_ff[AW-1:0];
      mem_wd        = '0;
      mem_ra        = cur_ff[AW-1:0];

      unique case (state_ff)
         ST_INIT0: begin
            mem_we   = 1'b1;
            mem_wa   = '0;
            mem_wd   = {SW'(HEAP_BYTES - HDR_BYTES), SW'(HEAP_BYTES - 2 * HDR_BYTES)};
            state_in = ST_INIT1;
         end
         ST_INIT1: begin
            mem_we   = 1'b1;
            mem_wa   = AW'(HEAP_BYTES - HDR_BYTES);
            mem_wd   = {END_S, {SW{1'b0}}};
            state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_if.valid) begin
               mode_in       = req_if.mode;
               req_in        = req_if.request_bytes;
               target_in     = req_if.free_offset - OFF_W'(HDR_BYTES);
               cur_in        = '0;
               have_prev_in  = 1'b0;
               res_status_in = STATUS_FAIL;
               res_off_in    = '0;
               state_in      = ST_RD;
               if (req_if.mode == MODE_ALLOC) begin
                  if (req_if.request_bytes == '0) state_in = ST_DONE;
               end else begin
                  if (req_if.free_offset < OFF_W'(HDR_BYTES)) state_in = ST_DONE;
               end
            end
         end
         ST_RD: begin
            // header would run past the heap: end of chain
            if (cur_ff + HDR_C > HEAP_C) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_EX;
            end
         end
         ST_EX: begin
            if (!rd_live) begin
               state_in = ST_DONE;
            end else if (mode_ff == MODE_ALLOC) begin
               if (!rd_size[0] && (RW'(rd_pay) >= RW'(req_ff))) begin
                  if (spare >= SPL_S) begin
                     hsize_in = req_s + HDR_S + keep + SW'(1);
                     rest_in  = {spare[SW-1:4], 4'b0000};
                     nh_in    = cur_ff + HDR_C + CW'(req_s) + CW'(keep);
                     state_in = ST_ASPLIT;
                  end else begin
                     hsize_in = req_s + HDR_S + spare + SW'(1);
                     state_in = ST_AHEAD;
                  end
               end else begin
                  cur_in   = cur_ff + CW'(rd_size_m);
                  state_in = ST_RD;
               end
            end else begin
               if (XW'(cur_ff) == XW'(target_ff)) begin
                  if (!rd_size[0]) begin
                     state_in = ST_DONE;
                  end else begin
                     hsize_in = rd_size_m;
                     state_in = ST_NRD;
                  end
               end else begin
                  prev_in      = cur_ff[AW-1:0];
                  prev_size_in = rd_size;
                  have_prev_in = 1'b1;
                  cur_in       = cur_ff + CW'(rd_size_m);
                  state_in     = ST_RD;
               end
            end
         end
         ST_ASPLIT: begin
            mem_wa = nh_ff[AW-1:0];
            mem_wd = {rest_ff, rest_ff - HDR_S};
            mem_we = (nh_ff < HEAP_C);
            state_in = ST_AHEAD;
         end
         ST_AHEAD: begin
            mem_we        = 1'b1;
            mem_wd        = {hsize_ff, req_s};
            res_status_in = STATUS_OK;
            res_off_in    = OFF_W'(cur_ff + HDR_C);
            state_in      = ST_DONE;
         end
         ST_NRD: begin
            mem_ra = nx[AW-1:0];
            if (nx + HDR_C > HEAP_C) begin
               // no next block: release as is
               mem_we        = 1'b1;
               mem_wd        = {hsize_ff, hsize_ff - HDR_S};
               res_status_in = STATUS_OK;
               state_in      = prev_merge ? ST_PMRG : ST_DONE;
            end else begin
               state_in = ST_NEX;
            end
         end
         ST_NEX: begin
            mem_we = 1'b1;
            if (!rd_size[0] && (rd_size != '0)) begin
               hsize_in = merged;
               mem_wd   = {merged, merged - HDR_S};
            end else begin
               mem_wd   = {hsize_ff, hsize_ff - HDR_S};
            end
            res_status_in = STATUS_OK;
            state_in      = prev_merge ? ST_PMRG : ST_DONE;
         end
         ST_PMRG: begin
            mem_we   = 1'b1;
            mem_wa   = prev_ff;
            mem_wd   = {pmerged, pmerged - HDR_S};
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_off_in    = res_off_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT0;
         rsp_valid_ff <= 1'b0;
         have_prev_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         have_prev_ff <= have_prev_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      req_ff        <= req_in;
      target_ff     <= target_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      prev_size_ff  <= prev_size_in;
      hsize_ff      <= hsize_in;
      nh_ff         <= nh_in;
      rest_ff       <= rest_in;
      res_status_ff <= res_status_in;
      res_off_ff    <= res_off_in;
      rsp_status_ff <= rsp_status_in;
      rsp_off_ff    <= rsp_off_in;
   end

endmodule

/* tb/first_fit_heap_allocator_tb.sv */
`timescale 1ns / 1ps

module first_fit_heap_allocator_tb import ffha_pkg::*; ();

   localparam int unsigned HEAP         = DEF_HEAP_BYTES;
   localparam int unsigned SIZE_MASK    = 32'hFFFF_FFFE;
   localparam int          RANDOM_ITEMS = 1000;
   localparam int          HOLD_CYCLES  = 400;
   localparam int          STALL_LIMIT  = 20000;
   localparam int          DRAIN_CYCLES = 40;

   typedef struct packed {
      logic             mode;
      logic [REQ_W-1:0] bytes;
      logic [OFF_W-1:0] offset;
   } heap_req_type;

   typedef struct packed {
      logic             status;
      logic [OFF_W-1:0] offset;
   } heap_rsp_type;

   typedef enum {RX_FREE_RUN, RX_HALF, RX_SPARSE, RX_PATTERN} rx_style_type;

   logic clock;
   logic reset;

   ffha_req_if req_bus ();
   ffha_rsp_if rsp_bus ();

   first_fit_heap_allocator #(
      .HEAP_BYTES (HEAP)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   // shadow heap: size word (size plus allocated bit) and payload length per byte offset
   int unsigned blk_word [HEAP];
   int unsigned blk_pay  [HEAP];

   heap_req_type heap_reqs_q[$];
   heap_rsp_type status_due_q[$];
   int unsigned  live_payloads[$];

   int           items_queued;
   int           items_taken;
   int           mismatches;
   int           hold_asks;
   int           holds_served;
   int           burst_left;
   int           gap_left;
   int           rx_left;
   int           rx_phase;
   int           hold_left;
   int           idle_cycles;
   rx_style_type rx_style;
   heap_req_type next_req;
   heap_rsp_type got_rsp;
   heap_rsp_type want_rsp;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic heap_reset();
      for (int i = 0; i < HEAP; i++) begin
         blk_word[i] = 0;
         blk_pay[i]  = 0;
      end
      blk_word[0]                = HEAP - HDR_BYTES;
      blk_pay[0]                 = HEAP - 2 * HDR_BYTES;
      blk_word[HEAP - HDR_BYTES] = END_MARK;
   endtask

   function automatic logic chain_live(int unsigned o);
      longint unsigned top;
      top = o;
      if (top + HDR_BYTES > HEAP) return 1'b0;
      if (blk_word[o] == END_MARK) return 1'b0;
      if ((blk_word[o] & SIZE_MASK) == 0) return 1'b0;
      return 1'b1;
   endfunction

   function automatic int unsigned chain_next(int unsigned o);
      longint unsigned n;
      n = o;
      n = n + (blk_word[o] & SIZE_MASK);
      return (n > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : n[31:0];
   endfunction

   function automatic logic heap_alloc(int unsigned req, output int unsigned where);
      int unsigned cur;
      int unsigned spare;
      int unsigned keep;
      int unsigned rest;
      int unsigned nh;
      cur   = 0;
      where = 0;
      if (req == 0) return 1'b0;
      while (chain_live(cur)) begin
         if (blk_word[cur][0] == 1'b0 && blk_pay[cur] >= req) begin
            spare = blk_pay[cur] - req;
            if (spare >= SPLIT_MIN) begin
               // allocated part keeps the odd spare bytes, the rest stays 16-aligned
               keep = spare % SPLIT_MIN;
               rest = spare - keep;
               nh   = cur + HDR_BYTES + req + keep;
               if (nh < HEAP) begin
                  blk_word[nh] = rest;
                  blk_pay[nh]  = rest - HDR_BYTES;
               end
               blk_word[cur] = req + HDR_BYTES + keep + 1;
            end else begin
               blk_word[cur] = req + HDR_BYTES + spare + 1;
            end
            blk_pay[cur] = req;
            where        = cur + HDR_BYTES;
            return 1'b1;
         end
         cur = chain_next(cur);
      end
      return 1'b0;
   endfunction

   function automatic logic heap_free(int unsigned off);
      int unsigned target;
      int unsigned cur;
      int unsigned prev;
      int unsigned nx;
      logic        have_prev;
      cur       = 0;
      prev      = 0;
      have_prev = 1'b0;
      if (off < HDR_BYTES) return 1'b0;
      target = off - HDR_BYTES;
      while (chain_live(cur) && cur != target) begin
         prev      = cur;
         have_prev = 1'b1;
         cur       = chain_next(cur);
      end
      if (!chain_live(cur)) return 1'b0;
      if (blk_word[cur][0] == 1'b0) return 1'b0;
      blk_word[cur] = blk_word[cur] & SIZE_MASK;
      blk_pay[cur]  = blk_word[cur] - HDR_BYTES;
      nx = chain_next(cur);
      if (chain_live(nx) && blk_word[nx][0] == 1'b0) begin
         blk_word[cur] = blk_word[cur] + blk_word[nx];
         blk_pay[cur]  = blk_word[cur] - HDR_BYTES;
      end
      if (have_prev && blk_word[prev][0] == 1'b0) begin
         blk_word[prev] = blk_word[prev] + blk_word[cur];
         blk_pay[prev]  = blk_word[prev] - HDR_BYTES;
      end
      return 1'b1;
   endfunction

   // runs on every accepted request, in order
   task automatic predict_transaction();
      logic         ok;
      int unsigned  where;
      heap_rsp_type due;
      where = 0;
      if (req_bus.mode == MODE_ALLOC) begin
         ok = heap_alloc(req_bus.request_bytes, where);
         if (ok) live_payloads.push_back(where);
      end else begin
         ok = heap_free(req_bus.free_offset);
         if (ok) begin
            for (int k = 0; k < live_payloads.size(); k++) begin
               if (live_payloads[k] == req_bus.free_offset) begin
                  live_payloads.delete(k);
                  break;
               end
            end
         end
      end
      due.status = ok ? STATUS_OK : STATUS_FAIL;
      due.offset = ok ? where[OFF_W-1:0] : '0;
      status_due_q.push_back(due);
      items_taken++;
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t mismatch: %s got %0d expected %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   task automatic push_item(input logic mode, input int unsigned bytes, input int unsigned off);
      heap_req_type item;
      item.mode   = mode;
      item.bytes  = (mode == MODE_ALLOC) ? bytes[REQ_W-1:0] : REQ_W'($urandom);
      item.offset = (mode == MODE_FREE) ? off[OFF_W-1:0] : OFF_W'($urandom);
      heap_reqs_q.push_back(item);
      items_queued++;
   endtask

   task automatic queue_random_item();
      int          sel;
      int          alloc_share;
      int unsigned bytes;
      int unsigned off;
      sel         = $urandom_range(99);
      alloc_share = (live_payloads.size() > 40) ? 30 : 55;
      if (sel < alloc_share) begin
         sel = $urandom_range(99);
         if (sel < 65) bytes = $urandom_range(1, 128);
         else if (sel < 88) bytes = $urandom_range(129, 1024);
         else if (sel < 96) bytes = $urandom_range(1025, 4096);
         else bytes = $urandom_range(0, 8191);
         push_item(MODE_ALLOC, bytes, 0);
      end else if (sel < 92 && live_payloads.size() > 0) begin
         push_item(MODE_FREE, 0, live_payloads[$urandom_range(live_payloads.size() - 1)]);
      end else begin
         // stray pointers: near a live block or anywhere
         if ($urandom_range(1) == 1 && live_payloads.size() > 0)
            off = live_payloads[$urandom_range(live_payloads.size() - 1)]
                  + $urandom_range(1, 15);
         else
            off = $urandom;
         push_item(MODE_FREE, 0, off);
      end
   endtask

   initial begin
      req_bus.valid         = 1'b0;
      req_bus.mode          = MODE_ALLOC;
      req_bus.request_bytes = '0;
      req_bus.free_offset   = '0;
      rsp_bus.ready         = 1'b0;
      reset                 = 1'b1;
      items_queued          = 0;
      items_taken           = 0;
      mismatches            = 0;
      hold_asks             = 0;
      holds_served          = 0;
      heap_reset();

      push_item(MODE_ALLOC, 0, 0);       // zero size
      push_item(MODE_FREE, 0, 0);        // below first payload
      push_item(MODE_FREE, 0, 8);        // block is free already
      push_item(MODE_ALLOC, 8191, 0);
      push_item(MODE_ALLOC, 4081, 0);    // one byte too many
      push_item(MODE_ALLOC, 4080, 0);    // whole heap, exact
      push_item(MODE_ALLOC, 1, 0);       // no fit left
      push_item(MODE_FREE, 0, 4088);     // end mark
      push_item(MODE_FREE, 0, 8);
      push_item(MODE_FREE, 0, 8);        // double free
      push_item(MODE_ALLOC, 4070, 0);    // spare below split size
      push_item(MODE_FREE, 0, 8);
      push_item(MODE_ALLOC, 1, 0);       // split
      push_item(MODE_ALLOC, 20, 0);
      push_item(MODE_ALLOC, 16, 0);
      push_item(MODE_FREE, 0, 4095);
      push_item(MODE_FREE, 0, 12);       // inside a block
      push_item(MODE_FREE, 0, 32);       // neighbors allocated
      push_item(MODE_FREE, 0, 64);       // merge both sides
      push_item(MODE_FREE, 0, 8);        // merge with next
      push_item(MODE_ALLOC, 4096, 0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         while (heap_reqs_q.size() >= 3) @(posedge clock);
         if (n == 300) hold_asks++;
         if (n == 650) begin
            while (items_taken != items_queued || status_due_q.size() > 0) @(posedge clock);
         end
         queue_random_item();
      end

      while (items_taken != items_queued) @(posedge clock);
      while (status_due_q.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         burst_left = 4;
         gap_left   = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) predict_transaction();
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_bus.valid <= 1'b0;
            end else if (heap_reqs_q.size() > 0) begin
               next_req = heap_reqs_q.pop_front();
               req_bus.valid         <= 1'b1;
               req_bus.mode          <= next_req.mode;
               req_bus.request_bytes <= next_req.bytes;
               req_bus.free_offset   <= next_req.offset;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = ($urandom_range(9) == 0) ? $urandom_range(60, 150)
                                                       : $urandom_range(1, 12);
                  gap_left   = $urandom_range(0, 5);
               end
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // response ready pattern, with one long hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rx_style  = RX_FREE_RUN;
         rx_left   = 0;
         rx_phase  = 0;
         hold_left = 0;
      end else begin
         if (hold_asks != holds_served) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
         end
         if (rx_left == 0) begin
            rx_style = rx_style_type'($urandom_range(3));
            rx_left  = $urandom_range(20, 200);
         end else begin
            rx_left--;
         end
         rx_phase++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            case (rx_style)
               RX_FREE_RUN: rsp_bus.ready <= 1'b1;
               RX_HALF:     rsp_bus.ready <= $urandom_range(1);
               RX_SPARSE:   rsp_bus.ready <= ($urandom_range(3) == 0);
               default:     rsp_bus.ready <= ((rx_phase % 7) < 4);
            endcase
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got_rsp.status = rsp_bus.status;
         got_rsp.offset = rsp_bus.payload_offset;
         if (status_due_q.size() == 0) begin
            report_mismatch("unexpected transaction, status", got_rsp.status, -1);
         end else begin
            want_rsp = status_due_q.pop_front();
            if (got_rsp.status !== want_rsp.status)
               report_mismatch("status", got_rsp.status, want_rsp.status);
            if (got_rsp.offset !== want_rsp.offset)
               report_mismatch("payload_offset", got_rsp.offset, want_rsp.offset);
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t watchdog expired with %0d results outstanding", $realtime,
                     status_due_q.size());
            $display("Some tests failed");
            $finish;
         end
      end
   end

endmodule
